// ----- hw/rtl/imurcf_pkg.sv -----
package imurcf_pkg;

    localparam int ANGLE_FRAC_BITS = 16;

    localparam int SMP_W    = 16;
    localparam int TIME_W   = 48;
    localparam int ANGLE_W  = 32;
    localparam int DT_W     = 34;
    localparam int Z_W      = 34;
    localparam int MA_W     = 40;
    localparam int MB_W     = 18;
    localparam int ACC_W    = 60;
    localparam int NUM_W    = 64;
    localparam int DEN_W    = 27;
    localparam int SUM_W    = 42;
    localparam int CNT_W    = 11;
    localparam int CFG_W    = 22;
    localparam int CFG_IDX_W = 2;

    localparam int CORDIC_STEPS = 20;
    localparam int STEP_W       = 5;
    localparam int DIV_CNT_W    = 6;

    localparam logic signed [Z_W-1:0]    HALF_PI_Q30 = 34'sd1686629712;
    localparam logic signed [TIME_W-1:0] DT_LIMIT    = 48'sd4294967295;
    localparam logic [16:0]              MIX_ONE     = 17'd32768;
    localparam logic [ACC_W-1:0]         MIX_HALF    = 60'd16384;
    localparam int                       MIX_SHIFT   = 15;
    localparam logic signed [MB_W-1:0]   DEG_SCALE   = 18'sd573;

    localparam logic [DEN_W-1:0] RAW_DEN   = DEN_W'(10 << (30 - ANGLE_FRAC_BITS));
    localparam logic [DEN_W-1:0] GYRO_DEN  = 27'd131000000;
    localparam logic [NUM_W-1:0] GYRO_HALF = 64'd65500000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWPASS_WEIGHT  = 2'd0,
        CFG_GYRO_WEIGHT     = 2'd1,
        CFG_CALIB_THRESHOLD = 2'd2,
        CFG_DEADBAND        = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_DT, S_CORD, S_RAWMUL, S_RAWDIV, S_RAWW,
        S_LP1, S_LP2, S_LP3, S_GMUL, S_GDIV, S_GW,
        S_F0, S_F1, S_F2, S_F3, S_CAL, S_CDIV, S_CW, S_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    function automatic logic signed [Z_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:  v = 34'sh03243F6A8;
            5'd1:  v = 34'sh01DAC6705;
            5'd2:  v = 34'sh00FADBAFC;
            5'd3:  v = 34'sh007F56EA6;
            5'd4:  v = 34'sh003FEAB76;
            5'd5:  v = 34'sh001FFD55B;
            5'd6:  v = 34'sh000FFFAAA;
            5'd7:  v = 34'sh0007FFF55;
            5'd8:  v = 34'sh0003FFFEA;
            5'd9:  v = 34'sh0001FFFFD;
            5'd10: v = 34'sh0000FFFFF;
            5'd11: v = 34'sh00007FFFF;
            5'd12: v = 34'sh00003FFFF;
            5'd13: v = 34'sh00001FFFF;
            5'd14: v = 34'sh00000FFFF;
            5'd15: v = 34'sh000007FFF;
            5'd16: v = 34'sh000003FFF;
            5'd17: v = 34'sh000001FFF;
            5'd18: v = 34'sh000000FFF;
            5'd19: v = 34'sh0000007FF;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [NUM_W-1:0] v);
        logic signed [ANGLE_W-1:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[ANGLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/imurcf_smp_if.sv -----
interface imurcf_smp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic [47:0]        time_us;

    modport source(output valid, accel_y, accel_z, gyro_x, time_us, input ready);
    modport sink(input valid, accel_y, accel_z, gyro_x, time_us, output ready);
endinterface

// ----- hw/rtl/imurcf_roll_if.sv -----
interface imurcf_roll_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] roll_out;
    logic               calibrated_flag;

    modport source(output valid, roll_out, calibrated_flag, input ready);
    modport sink(input valid, roll_out, calibrated_flag, output ready);
endinterface

// ----- hw/rtl/imurcf_cordic.sv -----
module imurcf_cordic (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [imurcf_pkg::SMP_W-1:0]  i_y,
    input  logic signed [imurcf_pkg::SMP_W-1:0]  i_x,
    output logic                                 o_done,
    output logic signed [imurcf_pkg::Z_W-1:0]    o_z
);
    import imurcf_pkg::*;

    logic                    r_busy;
    logic [STEP_W-1:0]       r_step;
    logic signed [Z_W-1:0]   r_xs, r_ys, r_z;
    logic                    r_zero;
    logic                    r_done;
    logic signed [Z_W-1:0]   xs0, ys0;
    logic signed [Z_W-1:0]   dx, dy;

    assign xs0 = {{(Z_W-SMP_W-14){i_x[SMP_W-1]}}, i_x, 14'd0};
    assign ys0 = {{(Z_W-SMP_W-14){i_y[SMP_W-1]}}, i_y, 14'd0};
    assign dx  = r_ys >>> r_step;
    assign dy  = r_xs >>> r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_zero <= (i_x == '0) && (i_y == '0);
            if (xs0 < 0) begin
                if (ys0 >= 0) begin
                    r_xs <= ys0;
                    r_ys <= -xs0;
                    r_z  <= HALF_PI_Q30;
                end else begin
                    r_xs <= -ys0;
                    r_ys <= xs0;
                    r_z  <= -HALF_PI_Q30;
                end
            end else begin
                r_xs <= xs0;
                r_ys <= ys0;
                r_z  <= '0;
            end
        end else if (r_busy) begin
            if (r_ys >= 0) begin
                r_xs <= r_xs + dx;
                r_ys <= r_ys - dy;
                r_z  <= r_z + atan_q30(r_step);
            end else begin
                r_xs <= r_xs - dx;
                r_ys <= r_ys + dy;
                r_z  <= r_z - atan_q30(r_step);
            end
        end
    end

    assign o_done = r_done;
    assign o_z    = r_zero ? '0 : r_z;
endmodule

// ----- hw/rtl/imurcf_div.sv -----
module imurcf_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  imurcf_pkg::t_div_req              i_req,
    output logic                              o_done,
    output logic [imurcf_pkg::NUM_W-1:0]      o_quot
);
    import imurcf_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]     r_num;
    logic [DEN_W:0]       r_rem;
    logic [DEN_W-1:0]     r_den;
    logic [DEN_W:0]       trial;
    logic                 fits;

    // restoring division, one quotient bit per cycle
    assign trial = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? trial - {1'b0, r_den} : trial;
            r_num <= {r_num[NUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
endmodule

// ----- hw/rtl/imu_roll_complementary_filter_core.sv -----
// roll estimator: complementary filter over imu samples
// i_smp carries one sample beat (accel y/z, gyro x, microsecond timestamp);
// o_roll returns exactly one beat per sample: roll after offset and deadband
// plus the calibrated flag. both channels use valid/ready, a beat moves when
// both are high. registers are written through i_cfg_we/i_cfg_idx/i_cfg_data
// and must only change while the block is idle.
// one sample at a time: i_smp.ready is high only in idle. a sample runs a
// 20-step cordic, two passes through the shared restoring divider (degree
// scaling and gyro step) and the shared multiplier for the degree and gyro
// products and the two weighted mixes. the sample that ends calibration takes
// a third divider pass for the offset mean. the divider sets the pace.
// the result sits in an output register; a new sample is accepted while it
// waits, and if the receiver still stalls when the next result is ready the
// sequencer holds until the register is free.
// synchronous reset clears the filter state kept between samples and loads the default registers.
module imu_roll_complementary_filter_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [imurcf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [imurcf_pkg::CFG_W-1:0]         i_cfg_data,
    imurcf_smp_if.sink                           i_smp,
    imurcf_roll_if.source                        o_roll
);
    import imurcf_pkg::*;

    // configuration
    logic [15:0]           r_cfg_lp, r_cfg_gw;
    logic [9:0]            r_cfg_thr;
    logic [21:0]           r_cfg_db;

    // sequencer and latched sample
    t_state                r_state, n_state;
    logic signed [SMP_W-1:0] r_ay, r_az, r_gx;
    logic [TIME_W-1:0]     r_now, r_prev;

    // filter state
    logic signed [DT_W-1:0]    r_dt;
    logic signed [Z_W-1:0]     r_z;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_neg;
    logic signed [ANGLE_W-1:0] r_raw, r_lp, r_fused, r_offset, r_held;
    logic signed [MA_W-1:0]    r_delta, r_sum;
    logic signed [SUM_W-1:0]   r_csum;
    logic [CNT_W-1:0]          r_ccnt;
    logic                      r_cal;

    // output register
    logic                      r_ov;
    logic signed [ANGLE_W-1:0] r_out;
    logic                      r_oflag;

    // cordic, shared divider and shared multiplier
    logic                      cord_start, cord_done;
    logic signed [Z_W-1:0]     cord_z;
    t_div_req                  div_req;
    logic                      div_done;
    logic [NUM_W-1:0]          div_quot;
    logic signed [NUM_W-1:0]   div_signed;

    logic                      mul_en, mul_accum;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [MA_W+MB_W-1:0] mul_p;

    logic [16:0]               w_lp, w_gw;
    logic signed [TIME_W-1:0]  dt_diff;
    logic signed [DT_W-1:0]    dt_new;
    logic [ACC_W-1:0]          acc_mag;
    logic signed [SUM_W-1:0]   csum_next;
    logic [CNT_W-1:0]          ccnt_next;
    logic [SUM_W-1:0]          csum_mag;
    logic signed [ANGLE_W:0]   held_diff;
    logic [ANGLE_W:0]          held_mag;
    logic out_free;

    imurcf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_y     (r_ay),
        .i_x     (r_az),
        .o_done  (cord_done),
        .o_z     (cord_z)
    );

    imurcf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    function automatic logic signed [ANGLE_W-1:0] mix_out(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] s;
        s = (a + $signed(MIX_HALF)) >>> MIX_SHIFT;
        return sat32(NUM_W'(s));
    endfunction

    // weights above one act as one
    assign w_lp = (r_cfg_lp > MIX_ONE) ? MIX_ONE : {1'b0, r_cfg_lp};
    assign w_gw = (r_cfg_gw > MIX_ONE) ? MIX_ONE : {1'b0, r_cfg_gw};

    // dt from the previous timestamp, zero on the first sample, clamped
    assign dt_diff = $signed(r_now - r_prev);
    always_comb begin
        if (r_prev == '0) begin
            dt_new = '0;
        end else if (dt_diff > DT_LIMIT) begin
            dt_new = DT_W'(DT_LIMIT);
        end else if (dt_diff < -DT_LIMIT) begin
            dt_new = DT_W'(-DT_LIMIT);
        end else begin
            dt_new = dt_diff[DT_W-1:0];
        end
    end

    assign acc_mag    = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : r_acc;
    assign div_signed = r_neg ? -$signed(div_quot) : $signed(div_quot);
    assign csum_next  = r_csum + SUM_W'(r_lp);
    assign ccnt_next  = r_ccnt + 1'b1;
    assign csum_mag   = r_csum[SUM_W-1] ? SUM_W'(-r_csum) : r_csum;
    assign held_diff  = (ANGLE_W+1)'(r_fused) - (ANGLE_W+1)'(r_offset);
    assign held_mag   = r_held[ANGLE_W-1] ? -(ANGLE_W+1)'(r_held) : (ANGLE_W+1)'(r_held);
    assign out_free   = !r_ov || o_roll.ready;

    assign mul_p = mul_a * mul_b;

    // sequencer: next state, unit starts and multiplier operands
    always_comb begin
        n_state     = r_state;
        cord_start  = 1'b0;
        div_req     = '0;
        mul_en      = 1'b0;
        mul_accum   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        unique case (r_state)
            S_IDLE:   if (i_smp.valid) n_state = S_DT;
            S_DT: begin
                cord_start = 1'b1;
                n_state    = S_CORD;
            end
            S_CORD:   if (cord_done) n_state = S_RAWMUL;
            S_RAWMUL: begin
                mul_en  = 1'b1;
                mul_a   = MA_W'(r_z);
                mul_b   = DEG_SCALE;
                n_state = S_RAWDIV;
            end
            S_RAWDIV: begin
                div_req.start = 1'b1;
                div_req.num   = NUM_W'(acc_mag) + NUM_W'(RAW_DEN >> 1);
                div_req.den   = RAW_DEN;
                n_state       = S_RAWW;
            end
            S_RAWW:   if (div_done) n_state = S_LP1;
            S_LP1: begin
                mul_en  = 1'b1;
                mul_a   = MA_W'(r_raw);
                mul_b   = $signed(MB_W'(w_lp));
                n_state = S_LP2;
            end
            S_LP2: begin
                mul_en    = 1'b1;
                mul_accum = 1'b1;
                mul_a     = MA_W'(r_lp);
                mul_b     = $signed(MB_W'(MIX_ONE - w_lp));
                n_state   = S_LP3;
            end
            S_LP3:    n_state = S_GMUL;
            S_GMUL: begin
                mul_en  = 1'b1;
                mul_a   = MA_W'(r_dt);
                mul_b   = MB_W'(r_gx);
                n_state = S_GDIV;
            end
            S_GDIV: begin
                div_req.start = 1'b1;
                div_req.num   = (NUM_W'(acc_mag) << ANGLE_FRAC_BITS) + GYRO_HALF;
                div_req.den   = GYRO_DEN;
                n_state       = S_GW;
            end
            S_GW:     if (div_done) n_state = S_F0;
            S_F0:     n_state = S_F1;
            S_F1: begin
                mul_en  = 1'b1;
                mul_a   = r_sum;
                mul_b   = $signed(MB_W'(w_gw));
                n_state = S_F2;
            end
            S_F2: begin
                mul_en    = 1'b1;
                mul_accum = 1'b1;
                mul_a     = MA_W'(r_lp);
                mul_b     = $signed(MB_W'(MIX_ONE - w_gw));
                n_state   = S_F3;
            end
            S_F3:     n_state = S_CAL;
            S_CAL: begin
                if (!r_cal && (ccnt_next > CNT_W'(r_cfg_thr))) begin
                    n_state = S_CDIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_CDIV: begin
                div_req.start = 1'b1;
                div_req.num   = NUM_W'(csum_mag) + NUM_W'(r_ccnt >> 1);
                div_req.den   = DEN_W'(r_ccnt);
                n_state       = S_CW;
            end
            S_CW:     if (div_done) n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_lp  <= 16'd3277;
            r_cfg_gw  <= 16'd32113;
            r_cfg_thr <= 10'd100;
            r_cfg_db  <= 22'd65536;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LOWPASS_WEIGHT:  r_cfg_lp  <= i_cfg_data[15:0];
                CFG_GYRO_WEIGHT:     r_cfg_gw  <= i_cfg_data[15:0];
                CFG_CALIB_THRESHOLD: r_cfg_thr <= i_cfg_data[9:0];
                CFG_DEADBAND:        r_cfg_db  <= i_cfg_data;
                default:             r_cfg_db  <= r_cfg_db;
            endcase
        end
    end

    // sample latch and datapath registers without reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_smp.valid) begin
            r_ay  <= i_smp.accel_y;
            r_az  <= i_smp.accel_z;
            r_gx  <= i_smp.gyro_x;
            r_now <= i_smp.time_us;
        end
        if (r_state == S_DT) r_dt <= dt_new;
        if (r_state == S_CORD && cord_done) r_z <= cord_z;
        if (mul_en) begin
            r_acc <= mul_accum ? r_acc + ACC_W'(mul_p) : ACC_W'(mul_p);
        end
        if (r_state == S_RAWDIV || r_state == S_GDIV) r_neg <= r_acc[ACC_W-1];
        if (r_state == S_CDIV) r_neg <= r_csum[SUM_W-1];
        if (r_state == S_RAWW && div_done) r_raw <= sat32(div_signed);
        if (r_state == S_GW && div_done) r_delta <= div_signed[MA_W-1:0];
        if (r_state == S_F0) r_sum <= MA_W'(r_fused) + r_delta;
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_lp     <= '0;
            r_fused  <= '0;
            r_csum   <= '0;
            r_ccnt   <= '0;
            r_cal    <= 1'b0;
            r_offset <= '0;
            r_held   <= '0;
        end else begin
            if (r_state == S_DT) r_prev <= r_now;
            if (r_state == S_LP3) r_lp <= mix_out(r_acc);
            if (r_state == S_F3) r_fused <= mix_out(r_acc);
            if (r_state == S_CAL) begin
                if (!r_cal) begin
                    r_csum <= csum_next;
                    r_ccnt <= ccnt_next;
                end else begin
                    r_held <= sat32(NUM_W'(held_diff));
                end
            end
            if (r_state == S_CW && div_done) begin
                r_offset <= sat32(div_signed);
                r_cal    <= 1'b1;
            end
        end
    end

    // output register, deadband applied on load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_ov <= 1'b1;
        end else if (o_roll.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out   <= (held_mag < (ANGLE_W+1)'(r_cfg_db)) ? '0 : r_held;
            r_oflag <= r_cal;
        end
    end

    // no beat is taken while reset is held
    assign i_smp.ready           = i_rst_n && (r_state == S_IDLE);
    assign o_roll.valid          = r_ov;
    assign o_roll.roll_out       = r_out;
    assign o_roll.calibrated_flag = r_oflag;

    // calibration never undoes itself
    a_cal_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal |=> r_cal) else $error("calibrated flag fell");

    // held roll stays zero until calibration is done
    a_held_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cal |-> (r_held == '0)) else $error("held roll moved before calibration");

    // an accepted beat starts the dt step
    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |=> (r_state == S_DT))
        else $error("sequencer missed accepted beat");

    // divider only finishes while the sequencer waits for it
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_RAWW || r_state == S_GW || r_state == S_CW))
        else $error("divider finished outside a wait state");
endmodule

// ----- test/tb_top.sv -----
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import imurcf_pkg::*;

    // one imu sample as offered on the input channel
    typedef struct {
        logic signed [SMP_W-1:0]  ay;
        logic signed [SMP_W-1:0]  az;
        logic signed [SMP_W-1:0]  gx;
        logic [TIME_W-1:0]        t;
    } t_sample;

    // one roll beat as it should leave the block
    typedef struct {
        logic signed [ANGLE_W-1:0] roll;
        logic                      calibrated;
    } t_roll;

    localparam longint GYRO_COUNTS_US = 64'sd131000000;
    localparam longint DT_CLAMP       = 64'sd4294967295;
    localparam int     LONG_HOLD      = 800;
    localparam int     SETTLE_CYCLES  = 300;

    // arctangent of 2^-i in q30 radians
    localparam longint ATAN_Q30 [CORDIC_STEPS] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_W-1:0]      cfg_data;

    imurcf_smp_if  smp ();
    imurcf_roll_if roll ();

    imu_roll_complementary_filter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_smp      (smp),
        .o_roll     (roll)
    );

    // stimulus and expectation stores
    t_sample  samples_to_send [$];
    t_roll    rolls_expected [$];
    t_sample  sample_on_bus;
    int       send_idle_pct;
    int       recv_stall_pct;
    bit       hold_req;
    int       hold_left;
    bit       failed;
    logic [TIME_W-1:0] stamp;

    // shadow copy of the register file
    longint lp_weight, gy_weight, calib_thresh, dead_band;

    // shadow copy of the filter state
    logic [TIME_W-1:0] last_time;
    longint lp_angle, fused, calib_acc, offset, roll_held;
    int     calib_n;
    bit     calibrated;

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // divide rounding half away from zero, den positive
    function automatic longint div_half_away(input longint num, input longint den);
        longint mag;
        longint q;
        mag = num < 0 ? -num : num;
        q = (mag + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    // q1.15 weighted blend, weight clamped to one, rounded half up
    function automatic longint blend_q15(input longint wreg, input longint a, input longint b);
        longint w;
        w = wreg > 32768 ? 32768 : wreg;
        return (w * a + (32768 - w) * b + 16384) >>> 15;
    endfunction

    // vectoring cordic, q30 radians
    function automatic longint atan2_q30(input longint y, input longint x);
        longint xs, ys, z, t, dx, dy;
        xs = x * 16384;
        ys = y * 16384;
        z = 0;
        if (x == 0 && y == 0) return 0;
        // left half plane: rotate by a quarter turn first
        if (xs < 0) begin
            if (ys >= 0) begin
                t = xs; xs = ys; ys = -t; z = HALF_PI_Q30;
            end else begin
                t = xs; xs = -ys; ys = t; z = -HALF_PI_Q30;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = ys >>> i;
            dy = xs >>> i;
            if (ys >= 0) begin
                xs += dx; ys -= dy; z += ATAN_Q30[i];
            end else begin
                xs -= dx; ys += dy; z -= ATAN_Q30[i];
            end
        end
        return z;
    endfunction

    // advance the filter by one sample and queue the roll it produces
    function automatic void roll_predict(input t_sample s);
        longint ay, az, gx, dt, raw, q, qa, whole, rem, delta, mag;
        logic signed [TIME_W-1:0] d48;
        t_roll r;
        ay = s.ay;
        az = s.az;
        gx = s.gx;
        dt = 0;
        if (last_time != 0) begin
            d48 = s.t - last_time;
            dt = d48;
            if (dt > DT_CLAMP) dt = DT_CLAMP;
            if (dt < -DT_CLAMP) dt = -DT_CLAMP;
        end
        last_time = s.t;

        // accel roll in degrees via 57.3 deg/rad
        raw = clip32(div_half_away(atan2_q30(ay, az) * 573,
                                   longint'(10) << (30 - ANGLE_FRAC_BITS)));
        lp_angle = clip32(blend_q15(lp_weight, raw, lp_angle));

        // gyro contribution over dt, split to keep the remainder exact
        q = gx * dt;
        qa = q < 0 ? -q : q;
        whole = qa / GYRO_COUNTS_US;
        rem = qa % GYRO_COUNTS_US;
        delta = whole * (longint'(1) << ANGLE_FRAC_BITS)
              + div_half_away(rem * (longint'(1) << ANGLE_FRAC_BITS), GYRO_COUNTS_US);
        if (q < 0) delta = -delta;
        fused = clip32(blend_q15(gy_weight, fused + delta, lp_angle));

        if (!calibrated) begin
            calib_acc += lp_angle;
            calib_n = (calib_n + 1) & 11'h7FF;
            if (calib_n > calib_thresh) begin
                offset = clip32(div_half_away(calib_acc, calib_n));
                calibrated = 1'b1;
            end
        end else begin
            roll_held = clip32(fused - offset);
        end

        mag = roll_held < 0 ? -roll_held : roll_held;
        r.roll = mag < dead_band ? 0 : roll_held[ANGLE_W-1:0];
        r.calibrated = calibrated;
        rolls_expected.push_back(r);
    endfunction

    // clock, plus known values on every input from time zero
    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_LOWPASS_WEIGHT;
        cfg_data = '0;
        smp.valid = 1'b0;
        smp.accel_y = '0;
        smp.accel_z = '0;
        smp.gyro_x = '0;
        smp.time_us = '0;
        roll.ready = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // sample driver: new beat whenever the bus is free, idling at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp.valid <= 1'b0;
        end else begin
            if (smp.valid && smp.ready) roll_predict(sample_on_bus);
            if (!smp.valid || smp.ready) begin
                if (samples_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    sample_on_bus = samples_to_send.pop_front();
                    smp.valid   <= 1'b1;
                    smp.accel_y <= sample_on_bus.ay;
                    smp.accel_z <= sample_on_bus.az;
                    smp.gyro_x  <= sample_on_bus.gx;
                    smp.time_us <= sample_on_bus.t;
                end else begin
                    smp.valid <= 1'b0;
                end
            end
        end
    end

    // roll monitor: random back-pressure, long hold on request, beat check
    always @(posedge i_clk) begin
        t_roll want;
        if (!i_rst_n) begin
            roll.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (roll.valid && roll.ready) begin
                if (rolls_expected.size() == 0) begin
                    $display("%0t: unexpected roll beat %0d flag %0d", $time,
                             roll.roll_out, roll.calibrated_flag);
                    failed = 1'b1;
                end else begin
                    want = rolls_expected.pop_front();
                    if (roll.roll_out !== want.roll) begin
                        $display("%0t: roll_out expected %0d actual %0d", $time,
                                 want.roll, roll.roll_out);
                        failed = 1'b1;
                    end
                    if (roll.calibrated_flag !== want.calibrated) begin
                        $display("%0t: calibrated_flag expected %0d actual %0d", $time,
                                 want.calibrated, roll.calibrated_flag);
                        failed = 1'b1;
                    end
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                roll.ready <= 1'b0;
            end else begin
                roll.ready <= $urandom_range(0, 99) >= recv_stall_pct;
            end
        end
    end

    task automatic add_sample(input int ay, input int az, input int gx,
                              input logic [TIME_W-1:0] t);
        t_sample s;
        s.ay = SMP_W'(ay);
        s.az = SMP_W'(az);
        s.gx = SMP_W'(gx);
        s.t  = t;
        samples_to_send.push_back(s);
    endtask

    // register write while the block is idle, shadow copy follows
    task automatic reg_write(input t_cfg_idx idx, input int unsigned val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[CFG_W-1:0];
        case (idx)
            CFG_LOWPASS_WEIGHT:  lp_weight    = val & 32'hFFFF;
            CFG_GYRO_WEIGHT:     gy_weight    = val & 32'hFFFF;
            CFG_CALIB_THRESHOLD: calib_thresh = val & 32'h3FF;
            CFG_DEADBAND:        dead_band    = val & 32'h3FFFFF;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // sender holds back until every beat has come home, then the block settles
    task automatic drain;
        while (samples_to_send.size() > 0 || smp.valid || rolls_expected.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly steady sampling at about a kilohertz, the rest noise and odd timestamps
    task automatic random_samples(input int n);
        int kind;
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                stamp = stamp + TIME_W'($urandom_range(700, 1300));
            end else if (kind < 88) begin
                stamp = TIME_W'({$urandom, $urandom});
            end else if (kind < 94) begin
                stamp = stamp - TIME_W'($urandom_range(1, 100000));
            end else if (kind < 97) begin
                stamp = stamp + TIME_W'({$urandom_range(0, 255), $urandom});
            end else begin
                stamp = '0;
            end
            if (kind < 60)
                add_sample($urandom_range(0, 8000) - 4000, $urandom_range(12000, 20000) - 16384 +
                           16384, $urandom_range(0, 4000) - 2000, stamp);
            else
                add_sample($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                           $urandom_range(0, 65535) - 32768, stamp);
        end
    endtask

    task automatic run_phase(input int n, input int s_idle, input int r_stall);
        send_idle_pct = s_idle;
        recv_stall_pct = r_stall;
        random_samples(n);
        drain();
    endtask

    initial begin
        failed = 1'b0;
        hold_req = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        stamp = '0;
        lp_weight = 3277;
        gy_weight = 32113;
        calib_thresh = 100;
        dead_band = 65536;
        last_time = '0;
        lp_angle = 0;
        fused = 0;
        calib_acc = 0;
        calib_n = 0;
        offset = 0;
        roll_held = 0;
        calibrated = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short calibration so most of the run sees the offset path
        reg_write(CFG_CALIB_THRESHOLD, 20);

        // directed: first sample at time zero, axes, quadrants, zero vector
        add_sample(0, 16384, 0, 48'd0);
        add_sample(0, 0, 0, 48'd1000);
        add_sample(32767, 0, 32767, 48'd2000);
        add_sample(-32768, 0, -32768, 48'd3000);
        add_sample(0, -32768, 131, 48'd4000);
        add_sample(100, -32768, -131, 48'd5000);
        add_sample(-100, -32768, 0, 48'd6000);
        add_sample(32767, 32767, 1, 48'd7000);
        add_sample(-32768, -32768, -1, 48'd8000);
        add_sample(32767, -32768, 0, 48'd9000);
        // timestamp stepping back, then jumps past the dt clamp both ways
        add_sample(5000, 16000, 32767, 48'd4500);
        add_sample(5000, 16000, 32767, 48'h0100_0000_0000);
        add_sample(-5000, 16000, -32768, 48'd10);
        add_sample(-5000, 16000, 32767, 48'hFFFF_FFFF_FFFF);
        // timestamp of zero: next sample sees no elapsed time
        add_sample(1, 1, 500, 48'd0);
        add_sample(-1, 1, 500, 48'd12000);
        add_sample(0, 32767, -500, 48'd13000);
        add_sample(0, -1, 0, 48'd14000);
        add_sample(-1, 0, 0, 48'd15000);
        add_sample(1, 0, 0, 48'd16000);
        add_sample(16384, 16384, 0, 48'd17000);
        add_sample(-16384, 16384, 0, 48'd18000);
        stamp = 48'd18000;
        drain();

        // weight above one, gyro ignored, no deadband; long receiver hold
        reg_write(CFG_LOWPASS_WEIGHT, 65535);
        reg_write(CFG_GYRO_WEIGHT, 0);
        reg_write(CFG_DEADBAND, 0);
        @(negedge i_clk) hold_req = 1'b1;
        run_phase(80, 0, 0);

        // accel ignored, pure gyro, widest deadband
        reg_write(CFG_LOWPASS_WEIGHT, 0);
        reg_write(CFG_GYRO_WEIGHT, 32768);
        reg_write(CFG_DEADBAND, 4194303);
        reg_write(CFG_CALIB_THRESHOLD, 1023);
        run_phase(60, 62, 0);

        reg_write(CFG_LOWPASS_WEIGHT, $urandom_range(0, 32768));
        reg_write(CFG_GYRO_WEIGHT, $urandom_range(0, 32768));
        reg_write(CFG_DEADBAND, $urandom_range(0, 200000));
        run_phase(80, 0, 62);

        // back to the reset weights and deadband, calibration threshold zero
        reg_write(CFG_LOWPASS_WEIGHT, 3277);
        reg_write(CFG_GYRO_WEIGHT, 32113);
        reg_write(CFG_DEADBAND, 65536);
        reg_write(CFG_CALIB_THRESHOLD, 0);
        run_phase(80, 9, 9);

        reg_write(CFG_LOWPASS_WEIGHT, 32768);
        reg_write(CFG_GYRO_WEIGHT, 65535);
        reg_write(CFG_DEADBAND, 1);
        run_phase(100, 62, 0);

        reg_write(CFG_LOWPASS_WEIGHT, $urandom_range(0, 65535));
        reg_write(CFG_GYRO_WEIGHT, $urandom_range(0, 65535));
        reg_write(CFG_DEADBAND, $urandom_range(0, 4194303));
        run_phase(100, 0, 0);

        if (!failed)
            $display("[imu_roll_complementary_filter_core] OK");
        else
            $display("[imu_roll_complementary_filter_core] ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("[imu_roll_complementary_filter_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/imurcf_pkg.sv
hw/rtl/imurcf_smp_if.sv
hw/rtl/imurcf_roll_if.sv
hw/rtl/imurcf_cordic.sv
hw/rtl/imurcf_div.sv
hw/rtl/imu_roll_complementary_filter_core.sv
test/tb_top.sv
